// ----- hw/rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 17;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TDATA_W  = 32;

  // framing constants
  localparam logic [BYTE_W-1:0] START_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] CHECK_BASE = 8'hFF;
  localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 16'd96;

  // frame status codes
  localparam logic [STATUS_W-1:0] ST_BUSY     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd3;

  // one result word
  typedef struct packed {
    logic [BYTE_W-1:0]   frame_byte;
    logic [INDEX_W-1:0]  byte_index;
    logic                last;
    logic [STATUS_W-1:0] frame_status;
  } result_t;

  // handoff from the input register to the parser
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } in_word_t;

endpackage

// ----- hw/rtl/serial_api_frame_receiver_top.sv -----
// ----------------------------------------------------------------------------
// serial_api_frame_receiver_top
// Length-prefixed frame receiver with an 8-bit sum checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per clock and passes on every byte of a frame with
// its index; the final byte carries last and a status (good, bad checksum,
// or too long when the length field exceeds the limit register). Bytes
// between frames are dropped. A byte moves from the input register through
// the parser into the result register, and one word is taken every cycle as
// long as the output side is ready. The user must write the limit register
// only while idle; the block itself does not enforce this.
module serial_api_frame_receiver_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [sfr_pkg::LEN_W-1:0]    cfg_wdata,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [sfr_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [sfr_pkg::TDATA_W-1:0]  m_tdata,   // [7:0] frame_byte, [24:8] byte_index
  output logic                         m_tlast,
  output logic [sfr_pkg::STATUS_W-1:0] m_tuser    // [1:0] frame_status
);

  sfr_pkg::in_word_t word;
  sfr_pkg::result_t  res;
  logic              res_valid;
  logic              open;
  logic              fire;

  // the parser consumes a byte when the result register can take it
  assign fire = word.valid && open;

  // input register
  sfr_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .consume  (fire),
    .word     (word)
  );

  // frame tracking
  sfr_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .word      (word),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  sfr_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && res_valid),
    .res      (res),
    .open     (open),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- hw/rtl/sfr_in_stage.sv -----
// ----------------------------------------------------------------------------
// sfr_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module sfr_in_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [sfr_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] rx_byte
  input  logic                        consume,
  output sfr_pkg::in_word_t           word
);

  logic                       held;
  logic [sfr_pkg::BYTE_W-1:0] data;

  // free when empty or being drained this cycle
  assign s_tready = !held || consume;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tready) begin
      held <= s_tvalid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      data <= s_tdata;
    end
  end

  assign word.valid = held;
  assign word.data  = data;

endmodule

// ----- hw/rtl/sfr_parse.sv -----
// ----------------------------------------------------------------------------
// sfr_parse
// Frame tracking: start hunt, length field, running sum and checksum test.
// ----------------------------------------------------------------------------
module sfr_parse (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [sfr_pkg::LEN_W-1:0]  cfg_wdata,
  input  sfr_pkg::in_word_t          word,
  input  logic                       fire,
  output logic                       res_valid,
  output sfr_pkg::result_t           res
);

  logic [sfr_pkg::LEN_W-1:0]   max_len;
  logic                        in_frame;
  logic                        in_frame_next;
  logic [sfr_pkg::INDEX_W-1:0] position;
  logic [sfr_pkg::INDEX_W-1:0] position_next;
  logic [sfr_pkg::INDEX_W-1:0] total_length;
  logic [sfr_pkg::INDEX_W-1:0] total_length_next;
  logic [sfr_pkg::BYTE_W-1:0]  length_high;
  logic [sfr_pkg::BYTE_W-1:0]  length_high_next;
  logic [sfr_pkg::BYTE_W-1:0]  running_sum;
  logic [sfr_pkg::BYTE_W-1:0]  running_sum_next;
  logic [sfr_pkg::INDEX_W-1:0] pos_inc;
  logic [sfr_pkg::LEN_W-1:0]   len;
  logic [sfr_pkg::BYTE_W-1:0]  expect_sum;

  assign pos_inc    = position + 1'b1;
  assign len        = {length_high, word.data};
  assign expect_sum = sfr_pkg::CHECK_BASE - running_sum;

  // next state and result for the byte at the input register
  always_comb begin
    in_frame_next      = in_frame;
    position_next      = position;
    total_length_next  = total_length;
    length_high_next   = length_high;
    running_sum_next   = running_sum;
    res_valid          = 1'b0;
    res.frame_byte     = word.data;
    res.byte_index     = pos_inc;
    res.last           = 1'b0;
    res.frame_status   = sfr_pkg::ST_BUSY;
    if (!in_frame) begin
      res.byte_index = '0;
      if (word.data == sfr_pkg::START_BYTE) begin
        res_valid         = 1'b1;
        in_frame_next     = 1'b1;
        position_next     = '0;
        total_length_next = '0;
        length_high_next  = '0;
        running_sum_next  = '0;
      end
    end else begin
      res_valid     = 1'b1;
      position_next = pos_inc;
      if (pos_inc == sfr_pkg::INDEX_W'(1)) begin
        length_high_next = word.data;
      end else if (pos_inc == sfr_pkg::INDEX_W'(2)) begin
        total_length_next = {1'b0, len} + sfr_pkg::INDEX_W'(4);
        if (len > max_len) begin
          in_frame_next    = 1'b0;
          res.last         = 1'b1;
          res.frame_status = sfr_pkg::ST_TOO_LONG;
        end
      end else if (({1'b0, pos_inc} + 1'b1) == {1'b0, total_length}) begin
        in_frame_next    = 1'b0;
        res.last         = 1'b1;
        res.frame_status = (expect_sum == word.data) ? sfr_pkg::ST_GOOD : sfr_pkg::ST_BAD;
      end else begin
        running_sum_next = running_sum + word.data;
      end
    end
  end

  // length limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= sfr_pkg::MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len <= cfg_wdata;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      position     <= '0;
      total_length <= '0;
      length_high  <= '0;
      running_sum  <= '0;
    end else if (fire) begin
      in_frame     <= in_frame_next;
      position     <= position_next;
      total_length <= total_length_next;
      length_high  <= length_high_next;
      running_sum  <= running_sum_next;
    end
  end

endmodule

// ----- hw/rtl/sfr_out_stage.sv -----
// ----------------------------------------------------------------------------
// sfr_out_stage
// Result register toward the output stream.
// ----------------------------------------------------------------------------
module sfr_out_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  sfr_pkg::result_t            res,
  output logic                        open,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [sfr_pkg::TDATA_W-1:0] m_tdata,   // [7:0] frame_byte, [24:8] byte_index
  output logic                        m_tlast,
  output logic [sfr_pkg::STATUS_W-1:0] m_tuser   // [1:0] frame_status
);

  localparam int unsigned PAD_W = sfr_pkg::TDATA_W - sfr_pkg::BYTE_W - sfr_pkg::INDEX_W;

  logic             full;
  sfr_pkg::result_t hold;

  // can take a new word when empty or being read out
  assign open = !full || m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (open) begin
      full <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (open && load) begin
      hold <= res;
    end
  end

  assign m_tvalid = full;
  assign m_tdata  = {{PAD_W{1'b0}}, hold.byte_index, hold.frame_byte};
  assign m_tlast  = hold.last;
  assign m_tuser  = hold.frame_status;

endmodule

// ----- hw/rtl/sfr_checker.sv -----
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks on the frame receiver output stream.
// ----------------------------------------------------------------------------
module sfr_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [sfr_pkg::TDATA_W-1:0]  m_tdata,
  input  logic                         m_tlast,
  input  logic [sfr_pkg::STATUS_W-1:0] m_tuser
);

  // a stalled word holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output word changed while stalled");

  // a final status comes exactly with last
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser != sfr_pkg::ST_BUSY)))
    else $error("last and frame status disagree");

  // index zero is always the start byte and never ends a frame
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[24:8] == '0) |-> (m_tdata[7:0] == sfr_pkg::START_BYTE) && !m_tlast)
    else $error("index zero word is not a start byte");

  // too long is only reported on the second length byte
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == sfr_pkg::ST_TOO_LONG) |-> (m_tdata[24:8] == 17'd2))
    else $error("too long status at wrong index");

  // output is empty after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind serial_api_frame_receiver_top sfr_checker u_sfr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial frame receiver.
// ----------------------------------------------------------------------------
// Starts with a short table of bytes: noise while hunting, zero length frames,
// a start byte as payload, bad checksums and length fields over the limit.
// After the table come random phases that each use their own length limit and
// one of four idle and stall patterns. Each phase mostly sends well-formed
// frames with random payload, mixed with noise, cut-off frames and over-long
// length fields. Every accepted byte runs through a local frame parser, and
// every output word is compared field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module tb;
  import sfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_WORDS  = 230;
  localparam int unsigned DRAIN_CYCLES = 6;

  typedef enum logic [1:0] {ROW_NONE, ROW_TYPED, ROW_PARSED} row_kind_t;

  typedef struct {
    logic [BYTE_W-1:0] rx;
    row_kind_t         kind;
    result_t           word;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [LEN_W-1:0]    cfg_wdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [BYTE_W-1:0]   s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;
  logic                m_tlast;
  logic [STATUS_W-1:0] m_tuser;

  // local frame parser state
  logic                frame_open = 1'b0;
  logic [INDEX_W-1:0]  frame_pos = '0;
  logic [INDEX_W-1:0]  frame_total = '0;
  logic [BYTE_W-1:0]   len_high = '0;
  logic [BYTE_W-1:0]   byte_sum = '0;
  logic [LEN_W-1:0]    max_len = MAX_LEN_RESET;

  result_t             pending_words[$];
  int unsigned         words_parsed = 0;
  int unsigned         fail_count = 0;
  int unsigned         cycle_count = 0;
  int unsigned         src_idle_pct = 0;
  int unsigned         sink_stall_pct = 0;

  serial_api_frame_receiver_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // parse one received byte, returns 1 when the byte yields an output word
  function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output result_t res);
    logic [LEN_W-1:0] len_field;
    res = '0;
    if (!frame_open) begin
      if (b != START_BYTE) return 1'b0;
      frame_open  = 1'b1;
      frame_pos   = '0;
      frame_total = '0;
      len_high    = '0;
      byte_sum    = '0;
      res = '{frame_byte: b, byte_index: '0, last: 1'b0, frame_status: ST_BUSY};
      return 1'b1;
    end
    frame_pos = frame_pos + 1'b1;
    res = '{frame_byte: b, byte_index: frame_pos, last: 1'b0, frame_status: ST_BUSY};
    if (frame_pos == 1) begin
      len_high = b;
    end else if (frame_pos == 2) begin
      len_field   = {len_high, b};
      frame_total = {1'b0, len_field} + 17'd4;
      // length over the limit aborts on the second length byte
      if (len_field > max_len) begin
        frame_open       = 1'b0;
        res.last         = 1'b1;
        res.frame_status = ST_TOO_LONG;
      end
    end else if (frame_pos + 1'b1 == frame_total) begin
      frame_open       = 1'b0;
      res.last         = 1'b1;
      res.frame_status = (BYTE_W'(CHECK_BASE - byte_sum) == b) ? ST_GOOD : ST_BAD;
    end else begin
      byte_sum = byte_sum + b;
    end
    return 1'b1;
  endfunction

  // present one byte, with random sender gaps, and wait until it is taken
  task automatic push_byte(input logic [BYTE_W-1:0] b, output bit has_word,
                           output result_t word);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    has_word = parse_byte(b, word);
    if (has_word) words_parsed++;
  endtask

  // byte whose expected word comes from the parser
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    bit      has_word;
    result_t word;
    push_byte(b, has_word, word);
    if (has_word) pending_words.push_back(word);
  endtask

  // wait until every expected word is out and the pipeline has emptied
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [LEN_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    max_len    = value;
  endtask

  // start byte, length, payload and checksum; aborts after the length when
  // it is over the limit, and can stop short inside the payload
  task automatic send_frame(input int unsigned len_field, input bit good_sum,
                            input bit cut_short);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    int unsigned       n_data;
    sum = '0;
    send_byte(START_BYTE);
    send_byte(len_field[15:8]);
    send_byte(len_field[7:0]);
    if (len_field > max_len) return;
    n_data = cut_short ? $urandom_range(0, len_field) : len_field;
    for (int unsigned i = 0; i < n_data; i++) begin
      b = BYTE_W'($urandom_range(0, 255));
      sum = sum + b;
      send_byte(b);
    end
    if (cut_short) return;
    if (good_sum) send_byte(CHECK_BASE - sum);
    else send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  // output side: random stalls and field-by-field compare
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_words.size() == 0) begin
          $error("unexpected word: data %h last %b user %h", m_tdata, m_tlast, m_tuser);
          fail_count++;
        end else begin
          want = pending_words.pop_front();
          if (m_tdata[BYTE_W-1:0] != want.frame_byte) begin
            $error("frame_byte: expected %h, got %h", want.frame_byte, m_tdata[BYTE_W-1:0]);
            fail_count++;
          end
          if (m_tdata[BYTE_W +: INDEX_W] != want.byte_index) begin
            $error("byte_index: expected %0d, got %0d", want.byte_index,
                   m_tdata[BYTE_W +: INDEX_W]);
            fail_count++;
          end
          if (m_tlast != want.last) begin
            $error("last: expected %b, got %b", want.last, m_tlast);
            fail_count++;
          end
          if (m_tuser != want.frame_status) begin
            $error("frame_status: expected %0d, got %0d", want.frame_status, m_tuser);
            fail_count++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // stimulus
  initial begin
    stim_row_t         rows[$];
    bit                has_word;
    result_t           word;
    int unsigned       phase_start;
    int unsigned       pick;
    int unsigned       lim;
    int unsigned       len;
    int unsigned       hi;
    logic [BYTE_W-1:0] noise;
    logic [LEN_W-1:0]  phase_max[8];

    phase_max = '{16'd96, 16'd0, 16'hFFFF, 16'd12, 16'd300, 16'd1, 16'd40, 16'hFFFE};

    // directed table, limit at its reset value
    rows = '{
      // noise while hunting
      '{8'h00, ROW_NONE,   '0},
      '{8'hFF, ROW_NONE,   '0},
      // zero length frame, good checksum
      '{8'h7E, ROW_TYPED,  '{8'h7E, 17'd0, 1'b0, ST_BUSY}},
      '{8'h00, ROW_TYPED,  '{8'h00, 17'd1, 1'b0, ST_BUSY}},
      '{8'h00, ROW_TYPED,  '{8'h00, 17'd2, 1'b0, ST_BUSY}},
      '{8'hFF, ROW_TYPED,  '{8'hFF, 17'd3, 1'b1, ST_GOOD}},
      // start byte as payload, wrong checksum
      '{8'h7E, ROW_PARSED, '0},
      '{8'h00, ROW_PARSED, '0},
      '{8'h01, ROW_PARSED, '0},
      '{8'h7E, ROW_PARSED, '0},
      '{8'h80, ROW_TYPED,  '{8'h80, 17'd4, 1'b1, ST_BAD}},
      // largest length field
      '{8'h7E, ROW_PARSED, '0},
      '{8'hFF, ROW_PARSED, '0},
      '{8'hFF, ROW_TYPED,  '{8'hFF, 17'd2, 1'b1, ST_TOO_LONG}},
      // one over the limit
      '{8'h7E, ROW_PARSED, '0},
      '{8'h00, ROW_PARSED, '0},
      '{8'h61, ROW_TYPED,  '{8'h61, 17'd2, 1'b1, ST_TOO_LONG}},
      // zero length frame, bad checksum
      '{8'h7E, ROW_PARSED, '0},
      '{8'h00, ROW_PARSED, '0},
      '{8'h00, ROW_PARSED, '0},
      '{8'h00, ROW_TYPED,  '{8'h00, 17'd3, 1'b1, ST_BAD}},
      // short frame with a wrapping sum
      '{8'h7E, ROW_PARSED, '0},
      '{8'h00, ROW_PARSED, '0},
      '{8'h02, ROW_PARSED, '0},
      '{8'hFF, ROW_PARSED, '0},
      '{8'hFF, ROW_PARSED, '0},
      '{8'h01, ROW_PARSED, '0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      push_byte(rows[i].rx, has_word, word);
      if (rows[i].kind == ROW_TYPED) pending_words.push_back(rows[i].word);
      else if (rows[i].kind == ROW_PARSED && has_word) pending_words.push_back(word);
    end
    drain();

    // random phases
    for (int p = 0; p < 8; p++) begin
      src_idle_pct   = (p % 4 == 1) ? 66 : (p % 4 == 3) ? 22 : 0;
      sink_stall_pct = (p % 4 == 2) ? 66 : (p % 4 == 3) ? 22 : 0;
      if (p != 0) write_max_len(phase_max[p]);
      lim = 32'(max_len);
      phase_start = words_parsed;
      while (words_parsed - phase_start < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // line noise, never a start byte
          repeat ($urandom_range(1, 4)) begin
            noise = BYTE_W'($urandom_range(0, 255));
            if (noise == START_BYTE) noise = noise ^ 8'h01;
            send_byte(noise);
          end
        end else if (pick < 14 && lim < 16'hFFFF) begin
          // length field over the limit
          hi = (lim + 200 > 16'hFFFF) ? 16'hFFFF : lim + 200;
          len = $urandom_range(0, 1) ? $urandom_range(lim + 1, hi)
                                     : $urandom_range(lim + 1, 16'hFFFF);
          send_frame(len, 1'b1, 1'b0);
        end else if (pick < 18) begin
          // frame cut off inside the payload
          send_frame($urandom_range(0, (lim < 40) ? lim : 40), 1'b1, 1'b1);
        end else begin
          if (pick < 22 && lim <= 300) len = lim;
          else len = $urandom_range(0, (lim < 40) ? lim : 40);
          send_frame(len, $urandom_range(0, 99) < 75, 1'b0);
        end
      end
      drain();
    end

    if (fail_count == 0 && pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_in_stage.sv
hw/rtl/sfr_parse.sv
hw/rtl/sfr_out_stage.sv
hw/rtl/serial_api_frame_receiver_top.sv
hw/rtl/sfr_checker.sv
verif/tb.sv
